@@ rtl/core/csvs_pkg.sv @@
// csvs_pkg: shared types and constants of the csv line summer
// byte classes, parse phases and the item passed from front to back
// no dependencies
package csvs_pkg;

    localparam int SUM_W       = 64;
    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SUM_W-1:0] VALUE_LIMIT = 64'h1999_9999_9999_9998;

    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        CLS_NEWLINE,
        CLS_COMMA,
        CLS_BLANK,
        CLS_DIGIT,
        CLS_OTHER,
        CLS_END
    } byte_class_t;

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_NAME,
        PH_PRE_NUM,
        PH_DIGITS,
        PH_POST_NUM,
        PH_ERROR
    } parse_phase_t;

    typedef struct packed {
        byte_class_t          cls;
        logic [DIGIT_W-1:0]   digit;
    } class_item_t;

endpackage

@@ rtl/core/csvs_front.sv @@
// csvs_front: accepts input items and classifies each byte
// holds one classified item until the queue takes it
// depends on csvs_pkg
module csvs_front
    import csvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              push,
    output class_item_t       push_item,
    input  logic              q_full
);

    logic        valid_reg;
    logic        valid_next;
    class_item_t item_reg;
    class_item_t item_next;
    logic        accept;

    assign push     = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_next.digit = DIGIT_W'(data_byte - CHAR_ZERO);
        if (cmd == CMD_END)
        begin
            item_next.cls = CLS_END;
        end
        else if (data_byte == CHAR_NEWLINE)
        begin
            item_next.cls = CLS_NEWLINE;
        end
        else if (data_byte == CHAR_COMMA)
        begin
            item_next.cls = CLS_COMMA;
        end
        else if (data_byte == CHAR_SPACE || data_byte == CHAR_TAB || data_byte == CHAR_CR)
        begin
            item_next.cls = CLS_BLANK;
        end
        else if (data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE)
        begin
            item_next.cls = CLS_DIGIT;
        end
        else
        begin
            item_next.cls = CLS_OTHER;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push_item = item_reg;

endmodule

@@ rtl/core/csvs_queue.sv @@
// csvs_queue: short fifo of classified items between front and back
// head item is shown while the queue is not empty
// depends on csvs_pkg
module csvs_queue
    import csvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  class_item_t push_item,
    output logic        q_full,
    input  logic        pop,
    output logic        q_valid,
    output class_item_t head_item
);

    class_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg;
    logic [QCNT_W-1:0]       count_next;

    assign q_full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid   = count_reg != '0;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/csvs_back.sv @@
// csvs_back: line parser, value accumulator and result register
// takes classified items from the queue, one per cycle, but an
// end item waits while a result is held; depends on csvs_pkg
module csvs_back
    import csvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  class_item_t      head_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SUM_W-1:0] sum,
    output logic             ok
);

    parse_phase_t      phase_reg;
    parse_phase_t      phase_next;
    parse_phase_t      cur_phase;
    logic              name_seen_reg;
    logic              name_seen_next;
    logic [SUM_W-1:0]  value_reg;
    logic [SUM_W-1:0]  value_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [SUM_W-1:0]  out_sum_next;
    logic              out_ok_reg;
    logic              out_ok_next;
    logic              is_end;
    logic              line_done;
    logic              good;
    logic [SUM_W-1:0]  value_x10;
    logic [SUM_W-1:0]  closed_sum;

    assign is_end = head_item.cls == CLS_END;
    assign pop    = q_valid && (!is_end || !out_valid_reg || !out_stall);

    assign cur_phase  = (phase_reg == PH_LINE_START) ? PH_NAME : phase_reg;
    assign line_done  = phase_reg == PH_DIGITS || phase_reg == PH_POST_NUM;
    assign good       = line_done || phase_reg == PH_LINE_START;
    assign closed_sum = sum_reg + value_reg;
    assign value_x10  = {value_reg[SUM_W-4:0], 3'b000} + {value_reg[SUM_W-2:0], 1'b0}
                      + SUM_W'(head_item.digit);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            if (is_end)
            begin
                phase_next = PH_LINE_START;
            end
            else if (phase_reg == PH_ERROR)
            begin
                phase_next = PH_ERROR;
            end
            else if (head_item.cls == CLS_NEWLINE)
            begin
                unique case (phase_reg)
                    PH_LINE_START:          phase_next = PH_LINE_START;
                    PH_DIGITS, PH_POST_NUM: phase_next = PH_LINE_START;
                    default:                phase_next = PH_ERROR;
                endcase
            end
            else
            begin
                unique case (cur_phase)
                    PH_NAME:
                    begin
                        if (head_item.cls == CLS_COMMA)
                        begin
                            phase_next = name_seen_reg ? PH_PRE_NUM : PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                    PH_PRE_NUM:
                    begin
                        if (head_item.cls == CLS_DIGIT)
                        begin
                            phase_next = PH_DIGITS;
                        end
                        else if (head_item.cls != CLS_BLANK)
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (head_item.cls == CLS_DIGIT)
                        begin
                            if (value_reg > VALUE_LIMIT)
                            begin
                                phase_next = PH_ERROR;
                            end
                        end
                        else if (head_item.cls == CLS_BLANK)
                        begin
                            phase_next = PH_POST_NUM;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_POST_NUM:
                    begin
                        if (head_item.cls != CLS_BLANK)
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    default: phase_next = PH_ERROR;
                endcase
            end
        end
    end

    // datapath and result
    always_comb
    begin
        name_seen_next = name_seen_reg;
        value_next     = value_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_sum_next   = out_sum_reg;
        out_ok_next    = out_ok_reg;
        if (pop)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                out_ok_next    = good;
                if (!good)
                begin
                    out_sum_next = '0;
                end
                else if (line_done)
                begin
                    out_sum_next = closed_sum;
                end
                else
                begin
                    out_sum_next = sum_reg;
                end
                name_seen_next = 1'b0;
                value_next     = '0;
                sum_next       = '0;
            end
            else if (phase_reg != PH_ERROR)
            begin
                if (head_item.cls == CLS_NEWLINE)
                begin
                    if (line_done)
                    begin
                        sum_next       = closed_sum;
                        name_seen_next = 1'b0;
                        value_next     = '0;
                    end
                end
                else if (cur_phase == PH_NAME)
                begin
                    if (head_item.cls != CLS_COMMA && head_item.cls != CLS_BLANK)
                    begin
                        name_seen_next = 1'b1;
                    end
                end
                else if (cur_phase == PH_PRE_NUM)
                begin
                    if (head_item.cls == CLS_DIGIT)
                    begin
                        value_next = SUM_W'(head_item.digit);
                    end
                end
                else if (cur_phase == PH_DIGITS)
                begin
                    if (head_item.cls == CLS_DIGIT && value_reg <= VALUE_LIMIT)
                    begin
                        value_next = value_x10;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            name_seen_reg <= 1'b0;
            value_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            name_seen_reg <= name_seen_next;
            value_reg     <= value_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sum_reg <= out_sum_next;
        out_ok_reg  <= out_ok_next;
    end

    assign out_valid = out_valid_reg;
    assign sum       = out_sum_reg;
    assign ok        = out_ok_reg;

endmodule

@@ rtl/core/csv_name_value_line_summer_unit.sv @@
// csv_name_value_line_summer_unit: top level of the csv line summer
// front classifier, item queue and back parser; depends on csvs_pkg,
// csvs_front, csvs_queue and csvs_back
//
//   channel   handshake             payload
//   input     in_valid / in_stall   cmd, data_byte
//   output    out_valid / out_stall sum, ok
//
// one item per cycle sustained unless a waiting result holds back an end item; the back parser updates the line value
// with one shift-add by ten and one limit compare per cycle
// an end item passes the front item register and a queue entry before the result register raises out_valid,
// later while the queue holds older items or a result still waits
// rst_n clears all control state at once, no clearing pass
// the four-entry queue lets the input keep flowing while a result waits
module csv_name_value_line_summer_unit
    import csvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SUM_W-1:0]  sum,
    output logic              ok
);

    logic        push;
    class_item_t push_item;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    class_item_t head_item;

    csvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_byte (data_byte),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    csvs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    csvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum       (sum),
        .ok        (ok)
    );

endmodule
